>>> hdl/additive_lagged_fibonacci_rng_unit_macros.svh
// assertion macros for the additive lagged fibonacci rng unit
// no dependencies; taken in by the top level only
`ifndef ADDITIVE_LAGGED_FIBONACCI_RNG_UNIT_MACROS_SVH
`define ADDITIVE_LAGGED_FIBONACCI_RNG_UNIT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ALFR_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("alfr assertion failed");

// next-cycle implication, checked out of reset
`define ALFR_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("alfr assertion failed");

`endif

>>> hdl/alfr_pkg.sv
// shared constants, types and helpers for the additive lagged fibonacci rng unit
// no dependencies
package alfr_pkg;

    localparam int DEPTH          = 55;
    localparam int ADDR_W         = 6;
    localparam int WORD_WIDTH_DEF = 16;
    localparam int OUT_W          = 16;
    localparam int IDX_W          = 6;
    localparam int SEED_W         = 16;
    localparam int IN_TDATA_W     = 24;

    localparam logic [ADDR_W-1:0] LEAD_RESET = ADDR_W'(54);
    localparam logic [ADDR_W-1:0] LAG_RESET  = ADDR_W'(23);
    // lag trails lead by this many entries, modulo the table depth
    localparam logic [ADDR_W-1:0] LAG_GAP    = ADDR_W'(54 - 23);
    localparam logic [ADDR_W-1:0] LAG_WRAP   = ADDR_W'(DEPTH - (54 - 23));
    localparam logic [ADDR_W-1:0] LAST_ADDR  = ADDR_W'(DEPTH - 1);

    localparam logic [SEED_W-1:0] SEED_WORDS [0:DEPTH-1] = '{
        16'd44292, 16'd60,    16'd4947,  16'd3972,  16'd4489,
        16'd1917,  16'd23916, 16'd7579,  16'd3048,  16'd56856,
        16'd11832, 16'd7589,  16'd1798,  16'd4954,  16'd2880,
        16'd5142,  16'd5187,  16'd3045,  16'd31529, 16'd3110,
        16'd4333,  16'd167,   16'd5556,  16'd7237,  16'd5906,
        16'd5419,  16'd56632, 16'd15833, 16'd3760,  16'd1081,
        16'd1434,  16'd80,    16'd6212,  16'd344,   16'd7303,
        16'd3044,  16'd7675,  16'd5420,  16'd19457, 16'd33434,
        16'd2657,  16'd700,   16'd6777,  16'd4436,  16'd620,
        16'd42129, 16'd629,   16'd23550, 16'd1639,  16'd4546,
        16'd1220,  16'd6469,  16'd862,   16'd3280,  16'd4664
    };

    typedef enum logic {
        MODE_DRAW = 1'b0,
        MODE_SEED = 1'b1
    } t_mode;

    typedef struct packed {
        logic              en;
        logic [ADDR_W-1:0] addr_a;
        logic [ADDR_W-1:0] addr_b;
    } t_rd_req;

    function automatic logic [ADDR_W-1:0] next_index(input logic [ADDR_W-1:0] idx);
        return (idx == LAST_ADDR) ? '0 : idx + ADDR_W'(1);
    endfunction

endpackage

>>> hdl/additive_lagged_fibonacci_rng_unit.sv
// additive lagged fibonacci random source (lags 31 and 55), 55-word table
// input channel: a transaction with tuser = 0 draws the next number; tuser = 1
// adds tdata seed_value into the table entry given by entry_index (indexes
// above 54 are dropped) and produces no output transaction.
// output channel: one transaction per draw carrying the updated lead word.
// timing: an accepted draw is registered in the table read register, then in
// the output register. throughput: one input transaction per cycle while not
// stalled; the read-then-add stage and the output register keep draws flowing
// with forwarding from the write port.
// reset: the table reads back the fixed seed words, lead index 54, lag 23;
// usable from the first cycle after reset.
// stall: while the output register holds an untaken result, a draw waiting
// behind it holds and the input ready drops; a seed in that stage never waits.
// depends on alfr_pkg, alfr_index, alfr_table and the macros header
`include "additive_lagged_fibonacci_rng_unit_macros.svh"

module additive_lagged_fibonacci_rng_unit #(
    parameter int WORD_WIDTH = alfr_pkg::WORD_WIDTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_tvalid,
    output logic                            o_s_tready,
    // entry_index [5:0], seed_value [21:6], zero pad [23:22]
    input  logic [alfr_pkg::IN_TDATA_W-1:0] i_s_tdata,
    // mode [0]
    input  logic                            i_s_tuser,
    output logic                            o_m_tvalid,
    input  logic                            i_m_tready,
    // random_value [15:0]
    output logic [alfr_pkg::OUT_W-1:0]      o_m_tdata
);

    alfr_pkg::t_mode             in_mode;
    logic [alfr_pkg::IDX_W-1:0]  in_idx;
    logic [alfr_pkg::SEED_W-1:0] in_seed;
    logic                        in_idx_ok;
    logic                        s_acc;
    logic                        in_draw;

    logic [alfr_pkg::ADDR_W-1:0] lead_nxt;
    logic [alfr_pkg::ADDR_W-1:0] lag_nxt;
    logic [alfr_pkg::ADDR_W-1:0] lag_exp;
    alfr_pkg::t_rd_req           rd_req;

    logic [WORD_WIDTH-1:0]       tbl_a;
    logic [WORD_WIDTH-1:0]       tbl_b;
    logic [WORD_WIDTH-1:0]       op_b;
    logic [WORD_WIDTH-1:0]       sum;
    logic                        s1_go;
    logic                        wr_en;
    logic                        out_load;

    logic                        r_s1_vld;
    logic                        r_s1_draw;
    logic                        r_s1_wr_ok;
    logic [alfr_pkg::ADDR_W-1:0] r_s1_addr;
    logic [alfr_pkg::SEED_W-1:0] r_s1_seed;
    logic                        r_out_vld;
    logic                        n_out_vld;
    logic [alfr_pkg::OUT_W-1:0]  r_out_data;

    assign in_mode   = alfr_pkg::t_mode'(i_s_tuser);
    assign in_idx    = i_s_tdata[alfr_pkg::IDX_W-1:0];
    assign in_seed   = i_s_tdata[alfr_pkg::IDX_W +: alfr_pkg::SEED_W];
    assign in_idx_ok = (in_idx < alfr_pkg::IDX_W'(alfr_pkg::DEPTH));
    assign s_acc     = i_s_tvalid && o_s_tready;
    assign in_draw   = (in_mode == alfr_pkg::MODE_DRAW);

    alfr_index u_index (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_adv      (s_acc && in_draw),
        .o_lead_nxt (lead_nxt),
        .o_lag_nxt  (lag_nxt)
    );

    // seed with a bad index reads entry 0 and writes nothing
    always_comb begin
        rd_req.en     = s_acc;
        rd_req.addr_a = in_draw ? lead_nxt : (in_idx_ok ? in_idx : '0);
        rd_req.addr_b = lag_nxt;
    end

    alfr_table #(
        .WORD_WIDTH (WORD_WIDTH)
    ) u_table (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd      (rd_req),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_s1_addr),
        .i_wr_data (sum),
        .o_rd_a    (tbl_a),
        .o_rd_b    (tbl_b)
    );

    assign op_b     = r_s1_draw ? tbl_b : WORD_WIDTH'(r_s1_seed);
    assign sum      = tbl_a + op_b;
    assign s1_go    = r_s1_vld && (!r_s1_draw || !r_out_vld || i_m_tready);
    assign wr_en    = s1_go && r_s1_wr_ok;
    assign out_load = s1_go && r_s1_draw;
    assign n_out_vld = out_load || (r_out_vld && !i_m_tready);

    assign o_s_tready = !r_s1_vld || s1_go;
    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (o_s_tready) begin
                r_s1_vld <= s_acc;
            end
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_acc) begin
            r_s1_draw  <= in_draw;
            r_s1_wr_ok <= in_draw || in_idx_ok;
            r_s1_addr  <= rd_req.addr_a;
            r_s1_seed  <= in_seed;
        end
        if (out_load) begin
            r_out_data <= sum[alfr_pkg::OUT_W-1:0];
        end
    end

    assign lag_exp = (lead_nxt >= alfr_pkg::LAG_GAP) ? lead_nxt - alfr_pkg::LAG_GAP
                                                     : lead_nxt + alfr_pkg::LAG_WRAP;

    `ALFR_ASSERT_NOW(a_lag_tracks_lead, i_clk, i_rst_n, 1'b1, lag_nxt == lag_exp)
    `ALFR_ASSERT_NOW(a_stall_cause, i_clk, i_rst_n, !o_s_tready,
        r_s1_vld && r_s1_draw && r_out_vld && !i_m_tready)
    `ALFR_ASSERT_NOW(a_write_in_range, i_clk, i_rst_n, wr_en,
        r_s1_addr <= alfr_pkg::LAST_ADDR)
    `ALFR_ASSERT_NEXT(a_seed_no_result, i_clk, i_rst_n,
        s1_go && !r_s1_draw && (!r_out_vld || i_m_tready), !o_m_tvalid)

endmodule

>>> hdl/alfr_index.sv
// lead and lag index counters, both stepping modulo the table depth
// depends on alfr_pkg
module alfr_index (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_adv,
    output logic [alfr_pkg::ADDR_W-1:0] o_lead_nxt,
    output logic [alfr_pkg::ADDR_W-1:0] o_lag_nxt
);

    logic [alfr_pkg::ADDR_W-1:0] r_lead;
    logic [alfr_pkg::ADDR_W-1:0] r_lag;

    assign o_lead_nxt = alfr_pkg::next_index(r_lead);
    assign o_lag_nxt  = alfr_pkg::next_index(r_lag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lead <= alfr_pkg::LEAD_RESET;
            r_lag  <= alfr_pkg::LAG_RESET;
        end else if (i_adv) begin
            r_lead <= o_lead_nxt;
            r_lag  <= o_lag_nxt;
        end
    end

endmodule

>>> hdl/alfr_table.sv
// word table: one write port, two registered read ports, valid bits over seed words
// depends on alfr_pkg
module alfr_table #(
    parameter int WORD_WIDTH = alfr_pkg::WORD_WIDTH_DEF
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  alfr_pkg::t_rd_req           i_rd,
    input  logic                        i_wr_en,
    input  logic [alfr_pkg::ADDR_W-1:0] i_wr_addr,
    input  logic [WORD_WIDTH-1:0]       i_wr_data,
    output logic [WORD_WIDTH-1:0]       o_rd_a,
    output logic [WORD_WIDTH-1:0]       o_rd_b
);

    logic [WORD_WIDTH-1:0]       mem [0:alfr_pkg::DEPTH-1];
    logic [alfr_pkg::DEPTH-1:0]  r_vld;

    logic [WORD_WIDTH-1:0]       r_rd_a;
    logic [WORD_WIDTH-1:0]       r_rd_b;
    logic [WORD_WIDTH-1:0]       r_byp_data;
    logic                        r_byp_a;
    logic                        r_byp_b;
    logic                        r_vld_a;
    logic                        r_vld_b;
    logic [alfr_pkg::ADDR_W-1:0] r_addr_a;
    logic [alfr_pkg::ADDR_W-1:0] r_addr_b;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_a <= mem[i_rd.addr_a];
            r_rd_b <= mem[i_rd.addr_b];
        end
    end

    // entries never written still read as their seed word
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_wr_en) begin
            r_vld[i_wr_addr] <= 1'b1;
        end
    end

    // a write in the same cycle as the read is forwarded
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_byp_a    <= i_wr_en && (i_wr_addr == i_rd.addr_a);
            r_byp_b    <= i_wr_en && (i_wr_addr == i_rd.addr_b);
            r_byp_data <= i_wr_data;
            r_vld_a    <= r_vld[i_rd.addr_a];
            r_vld_b    <= r_vld[i_rd.addr_b];
            r_addr_a   <= i_rd.addr_a;
            r_addr_b   <= i_rd.addr_b;
        end
    end

    assign o_rd_a = r_byp_a ? r_byp_data :
                    r_vld_a ? r_rd_a : WORD_WIDTH'(alfr_pkg::SEED_WORDS[r_addr_a]);
    assign o_rd_b = r_byp_b ? r_byp_data :
                    r_vld_b ? r_rd_b : WORD_WIDTH'(alfr_pkg::SEED_WORDS[r_addr_b]);

endmodule

>>> dv/tb_additive_lagged_fibonacci_rng_unit.sv
// self-checking testbench for additive_lagged_fibonacci_rng_unit: directed and random
// draw/seed transactions, checked against a lagged-sum table tracker kept in step
// depends on alfr_pkg and the unit's rtl
module tb_additive_lagged_fibonacci_rng_unit;

    localparam int WORD_W      = alfr_pkg::WORD_WIDTH_DEF;
    localparam int RAND_ITEMS  = 1950;
    localparam int QUIET_TAIL  = 300;
    localparam int STALL_LIMIT = 1000;

    // keeps its own copy of the table and indexes, and the draws still owed
    class lagged_sum_tracker;
        logic [WORD_W-1:0]                words [alfr_pkg::DEPTH];
        logic [alfr_pkg::ADDR_W-1:0]      lead_pos;
        logic [alfr_pkg::ADDR_W-1:0]      lag_pos;
        logic [alfr_pkg::OUT_W-1:0]       pending_values [$];
        int                               mismatches;
        int                               draws_seen;
        int                               seeds_seen;
        int                               seeds_dropped;

        function new();
            for (int i = 0; i < alfr_pkg::DEPTH; i++) begin
                words[i] = WORD_W'(alfr_pkg::SEED_WORDS[i]);
            end
            lead_pos      = alfr_pkg::LEAD_RESET;
            lag_pos       = alfr_pkg::LAG_RESET;
            mismatches    = 0;
            draws_seen    = 0;
            seeds_seen    = 0;
            seeds_dropped = 0;
        endfunction

        function logic [alfr_pkg::ADDR_W-1:0] step_pos(logic [alfr_pkg::ADDR_W-1:0] pos);
            return (int'(pos) == alfr_pkg::DEPTH - 1) ? '0 : pos + 1'b1;
        endfunction

        function void absorb_input(alfr_pkg::t_mode mode,
                                   logic [alfr_pkg::IDX_W-1:0] entry,
                                   logic [alfr_pkg::SEED_W-1:0] value);
            if (mode == alfr_pkg::MODE_SEED) begin
                seeds_seen++;
                if (int'(entry) < alfr_pkg::DEPTH) begin
                    words[entry] = words[entry] + WORD_W'(value);
                end else begin
                    seeds_dropped++;
                end
            end else begin
                lead_pos        = step_pos(lead_pos);
                lag_pos         = step_pos(lag_pos);
                words[lead_pos] = words[lead_pos] + words[lag_pos];
                pending_values.push_back(words[lead_pos][alfr_pkg::OUT_W-1:0]);
            end
        endfunction

        function void compare_output(logic [alfr_pkg::OUT_W-1:0] actual);
            logic [alfr_pkg::OUT_W-1:0] wanted;
            if (pending_values.size() == 0) begin
                $error("unexpected output transaction, random_value actual %0d", actual);
                mismatches++;
                return;
            end
            wanted = pending_values.pop_front();
            draws_seen++;
            if (actual !== wanted) begin
                $error("random_value mismatch: expected %0d, actual %0d", wanted, actual);
                mismatches++;
            end
        endfunction

        function void check_drained();
            if (pending_values.size() != 0) begin
                $error("%0d draws never came out", pending_values.size());
                mismatches++;
            end
        endfunction
    endclass

    logic                            i_clk      = 1'b0;
    logic                            i_rst_n    = 1'b0;
    logic                            i_s_tvalid = 1'b0;
    logic                            o_s_tready;
    logic [alfr_pkg::IN_TDATA_W-1:0] i_s_tdata  = '0;
    logic                            i_s_tuser  = 1'b0;
    logic                            o_m_tvalid;
    logic                            i_m_tready = 1'b0;
    logic [alfr_pkg::OUT_W-1:0]      o_m_tdata;

    lagged_sum_tracker tracker;
    bit                calm       = 1'b0;
    int                sink_hold  = 0;
    int                idle_count = 0;

    additive_lagged_fibonacci_rng_unit #(
        .WORD_WIDTH(WORD_W)
    ) dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .i_s_tuser  (i_s_tuser),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata)
    );

    always #6 i_clk = ~i_clk;

    // both channels observed at the edge, before any update of that edge lands
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_tvalid && o_s_tready) begin
                tracker.absorb_input(alfr_pkg::t_mode'(i_s_tuser),
                                     i_s_tdata[alfr_pkg::IDX_W-1:0],
                                     i_s_tdata[alfr_pkg::IDX_W +: alfr_pkg::SEED_W]);
            end
            if (o_m_tvalid && i_m_tready) begin
                tracker.compare_output(o_m_tdata);
            end
        end
    end

    // output side back-pressure in short random bursts
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold  <= sink_hold - 1;
            i_m_tready <= 1'b0;
        end else if (!calm && $urandom_range(0, 9) == 0) begin
            sink_hold  <= $urandom_range(0, 7);
            i_m_tready <= 1'b0;
        end else begin
            i_m_tready <= 1'b1;
        end
    end

    initial begin
        while (idle_count < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready)) begin
                idle_count = 0;
            end else begin
                idle_count++;
            end
        end
        $display("FAILURE");
        $finish;
    end

    task automatic send_item(alfr_pkg::t_mode mode, logic [alfr_pkg::IDX_W-1:0] entry,
                             logic [alfr_pkg::SEED_W-1:0] value);
        int gap;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 8);
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tuser  <= mode;
        i_s_tdata  <= {2'b00, value, entry};
        do begin
            @(posedge i_clk);
        end while (!o_s_tready);
    endtask

    task automatic drain_draws();
        i_s_tvalid <= 1'b0;
        while (tracker.pending_values.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic send_random(int count);
        logic [alfr_pkg::IDX_W-1:0] entry;
        for (int n = 0; n < count; n++) begin
            calm = (n >= 600 && n < 800) || (n >= count - QUIET_TAIL);
            if (n == count / 2) begin
                drain_draws();
            end
            // in-range entries mostly, the dropped range now and then
            entry = ($urandom_range(0, 7) == 0) ?
                    alfr_pkg::IDX_W'($urandom_range(alfr_pkg::DEPTH, 63)) :
                    alfr_pkg::IDX_W'($urandom_range(0, alfr_pkg::DEPTH - 1));
            if ($urandom_range(0, 3) == 0) begin
                send_item(alfr_pkg::MODE_SEED, entry, alfr_pkg::SEED_W'($urandom));
            end else begin
                send_item(alfr_pkg::MODE_DRAW, alfr_pkg::IDX_W'($urandom),
                          alfr_pkg::SEED_W'($urandom));
            end
        end
    endtask

    initial begin
        tracker = new();
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // first draw wraps the lead index from the top entry to zero
        send_item(alfr_pkg::MODE_DRAW, '0, '0);
        send_item(alfr_pkg::MODE_DRAW, '1, '1);
        send_item(alfr_pkg::MODE_SEED, 6'd0, 16'hffff);
        send_item(alfr_pkg::MODE_SEED, 6'd54, 16'h0001);
        send_item(alfr_pkg::MODE_SEED, 6'd55, 16'h1234);
        send_item(alfr_pkg::MODE_SEED, 6'd63, 16'hffff);
        send_item(alfr_pkg::MODE_SEED, 6'd27, 16'h0000);
        send_item(alfr_pkg::MODE_SEED, 6'd2, 16'h8000);
        send_item(alfr_pkg::MODE_DRAW, 6'd63, 16'hffff);
        send_item(alfr_pkg::MODE_DRAW, 6'd2, 16'h5a5a);
        // seed an entry just ahead of the lead, then draw it
        send_item(alfr_pkg::MODE_SEED, 6'd4, 16'hfffe);
        send_item(alfr_pkg::MODE_DRAW, '0, '0);
        for (int k = 0; k < 8; k++) begin
            send_item(alfr_pkg::MODE_DRAW, alfr_pkg::IDX_W'(k * 7),
                      alfr_pkg::SEED_W'(k << 13));
        end
        drain_draws();

        send_random(RAND_ITEMS);

        i_s_tvalid <= 1'b0;
        while (tracker.pending_values.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        tracker.check_drained();

        $display("covered %0d draws checked and %0d seed transactions, %0d of them",
                 tracker.draws_seen, tracker.seeds_seen, tracker.seeds_dropped);
        $display("aimed at entries beyond the table, with stalls on both channels");
        if (tracker.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
